// ----- hw/rtl/cffa_pkg.sv -----
// cffa_pkg: shared codes, control word types and the microcode table for the
// circular first-fit allocator. Used by the sequencer, datapath and checker.
// Depends on nothing.
package cffa_pkg;

    // result status codes
    localparam logic [1:0] ST_ALLOC   = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FREED   = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    // fixed field widths
    localparam int REQ_W  = 13;
    localparam int ADDR_W = 10;
    localparam int NEED_W = 14;

    // step counter codes
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] PC_A0    = 4'd1;
    localparam logic [PC_W-1:0] PC_A1    = 4'd2;
    localparam logic [PC_W-1:0] PC_A2    = 4'd3;
    localparam logic [PC_W-1:0] PC_FIT   = 4'd4;
    localparam logic [PC_W-1:0] PC_FIT2  = 4'd5;
    localparam logic [PC_W-1:0] PC_ADV   = 4'd6;
    localparam logic [PC_W-1:0] PC_NONE  = 4'd7;
    localparam logic [PC_W-1:0] PC_F0    = 4'd8;
    localparam logic [PC_W-1:0] PC_F1    = 4'd9;
    localparam logic [PC_W-1:0] PC_DONE  = 4'd10;
    localparam logic [PC_W-1:0] PC_CLR   = 4'd11;

    // datapath operation codes
    localparam logic [3:0] DP_IDLE    = 4'd0;
    localparam logic [3:0] DP_ROVER   = 4'd1;
    localparam logic [3:0] DP_LOADP   = 4'd2;
    localparam logic [3:0] DP_MERGE   = 4'd3;
    localparam logic [3:0] DP_SPLIT   = 4'd4;
    localparam logic [3:0] DP_TAKE    = 4'd5;
    localparam logic [3:0] DP_ADVANCE = 4'd6;
    localparam logic [3:0] DP_NOSPACE = 4'd7;
    localparam logic [3:0] DP_FREERD  = 4'd8;
    localparam logic [3:0] DP_FREEWR  = 4'd9;
    localparam logic [3:0] DP_HOLD    = 4'd10;
    localparam logic [3:0] DP_CLEAR   = 4'd11;

    // jump condition codes
    localparam logic [2:0] C_ALWAYS   = 3'd0;
    localparam logic [2:0] C_PBUSY    = 3'd1;
    localparam logic [2:0] C_QBUSY    = 3'd2;
    localparam logic [2:0] C_NOFIT    = 3'd3;
    localparam logic [2:0] C_ADVSTOP  = 3'd4;
    localparam logic [2:0] C_OUTRANGE = 3'd5;
    localparam logic [2:0] C_OUTHELD  = 3'd6;
    localparam logic [2:0] C_CLRLAST  = 3'd7;

    // one control word
    typedef struct packed {
        logic [3:0]      op;
        logic [2:0]      cond;
        logic [PC_W-1:0] jt;
        logic [PC_W-1:0] jf;
        logic            abort;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        logic [3:0] op;
        logic       start;
    } t_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic pbusy;
        logic qbusy;
        logic over;
        logic nofit;
        logic advstop;
        logic outrange;
        logic clrlast;
    } t_flags;

    // microcode table
    function automatic t_uword f_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: DP_IDLE, cond: C_ALWAYS, jt: PC_IDLE, jf: PC_IDLE, abort: 1'b0};
        unique case (pc)
            PC_IDLE: w = '{DP_IDLE,    C_ALWAYS,   PC_IDLE, PC_IDLE, 1'b0};
            PC_A0:   w = '{DP_ROVER,   C_ALWAYS,   PC_A1,   PC_A1,   1'b0};
            PC_A1:   w = '{DP_LOADP,   C_PBUSY,    PC_ADV,  PC_A2,   1'b0};
            PC_A2:   w = '{DP_MERGE,   C_QBUSY,    PC_FIT,  PC_A2,   1'b1};
            PC_FIT:  w = '{DP_SPLIT,   C_NOFIT,    PC_ADV,  PC_FIT2, 1'b0};
            PC_FIT2: w = '{DP_TAKE,    C_ALWAYS,   PC_DONE, PC_DONE, 1'b0};
            PC_ADV:  w = '{DP_ADVANCE, C_ADVSTOP,  PC_NONE, PC_A1,   1'b0};
            PC_NONE: w = '{DP_NOSPACE, C_ALWAYS,   PC_DONE, PC_DONE, 1'b0};
            PC_F0:   w = '{DP_FREERD,  C_OUTRANGE, PC_DONE, PC_F1,   1'b0};
            PC_F1:   w = '{DP_FREEWR,  C_ALWAYS,   PC_DONE, PC_DONE, 1'b0};
            PC_DONE: w = '{DP_HOLD,    C_OUTHELD,  PC_DONE, PC_IDLE, 1'b0};
            PC_CLR:  w = '{DP_CLEAR,   C_CLRLAST,  PC_IDLE, PC_CLR,  1'b0};
            default: w = '{DP_IDLE,    C_ALWAYS,   PC_IDLE, PC_IDLE, 1'b0};
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/cffa_seq.sv -----
// cffa_seq: step counter and microcode fetch for the allocator.
// Evaluates jump conditions from datapath flags. Depends on cffa_pkg.
module cffa_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_op,
    input  logic                  i_out_free,
    input  cffa_pkg::t_flags      i_flags,
    output cffa_pkg::t_ctrl       o_ctrl,
    output logic                  o_idle,
    output logic                  o_load
);

    logic [cffa_pkg::PC_W-1:0] r_pc;
    logic [cffa_pkg::PC_W-1:0] n_pc;
    cffa_pkg::t_uword          w;
    logic                      taken;

    // fetch the current control word
    assign w = cffa_pkg::f_rom(r_pc);

    // condition select
    always_comb begin
        unique case (w.cond)
            cffa_pkg::C_ALWAYS:   taken = 1'b1;
            cffa_pkg::C_PBUSY:    taken = i_flags.pbusy;
            cffa_pkg::C_QBUSY:    taken = i_flags.qbusy;
            cffa_pkg::C_NOFIT:    taken = i_flags.nofit;
            cffa_pkg::C_ADVSTOP:  taken = i_flags.advstop;
            cffa_pkg::C_OUTRANGE: taken = i_flags.outrange;
            cffa_pkg::C_OUTHELD:  taken = !i_out_free;
            cffa_pkg::C_CLRLAST:  taken = i_flags.clrlast;
            default:              taken = 1'b1;
        endcase
    end

    assign o_idle       = (r_pc == cffa_pkg::PC_IDLE);
    assign o_ctrl.op    = w.op;
    assign o_ctrl.start = o_idle && i_in_valid;
    assign o_load       = (r_pc == cffa_pkg::PC_DONE) && i_out_free;

    // next step
    always_comb begin
        if (o_idle) begin
            if (i_in_valid) begin
                n_pc = i_op ? cffa_pkg::PC_F0 : cffa_pkg::PC_A0;
            end else begin
                n_pc = cffa_pkg::PC_IDLE;
            end
        end else if (taken) begin
            n_pc = w.jt;
        end else if (w.abort && i_flags.over) begin
            n_pc = cffa_pkg::PC_NONE;
        end else begin
            n_pc = w.jf;
        end
    end

    // step counter, clearing pass first after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= cffa_pkg::PC_CLR;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ----- hw/rtl/cffa_dp.sv -----
// cffa_dp: header memory, walk registers and result registers of the allocator.
// Driven one operation per cycle by cffa_seq. Depends on cffa_pkg.
module cffa_dp #(
    parameter int ARENA_WORDS    = 1024,
    parameter int BYTES_PER_WORD = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cffa_pkg::t_ctrl             i_ctrl,
    input  logic [cffa_pkg::REQ_W-1:0]  i_request_bytes,
    input  logic [cffa_pkg::ADDR_W-1:0] i_free_address,
    output cffa_pkg::t_flags            o_flags,
    output logic [1:0]                  o_status,
    output logic [cffa_pkg::ADDR_W-1:0] o_address
);

    localparam int AW = $clog2(ARENA_WORDS);
    localparam int HW = AW + 1;
    localparam int SW = $clog2(4 * ARENA_WORDS + 2);
    localparam int NW = cffa_pkg::NEED_W;
    localparam int RW = cffa_pkg::ADDR_W;
    localparam int DW = ((AW > NW) ? AW : NW) + 1;
    localparam int CW = (AW > RW) ? AW : RW;
    localparam logic [AW-1:0] TOP    = AW'(ARENA_WORDS - 1);
    localparam logic [SW-1:0] BUDGET = SW'(4 * ARENA_WORDS);

    // header store: link in the upper bits, busy mark in bit 0
    logic [HW-1:0] mem [ARENA_WORDS];
    logic [HW-1:0] r_rdata;
    logic [AW-1:0] ra, wa;
    logic [HW-1:0] wd;
    logic          we;

    logic [AW-1:0] r_p, r_q, r_hp_link, r_cut, r_clr;
    logic          r_hp_busy, r_wrapped;
    logic [SW-1:0] r_steps;
    logic [NW-1:0] r_need;
    logic [RW-1:0] r_ap, r_rover;
    logic [1:0]    r_status;
    logic [RW-1:0] r_address;

    logic [AW-1:0] n_p, n_q, n_hp_link, n_cut, n_clr;
    logic          n_hp_busy, n_wrapped;
    logic [SW-1:0] n_steps;
    logic [NW-1:0] n_need;
    logic [RW-1:0] n_ap, n_rover;
    logic [1:0]    n_status;
    logic [RW-1:0] n_address;

    logic [HW-1:0] q_hdr;
    logic [AW-1:0] q_link, rd_link, ap_idx, cut;
    logic [SW-1:0] steps_inc;
    logic [DW-1:0] span, cut_sum;
    logic [NW-1:0] need_sum;
    logic          fit, in_range, over;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rdata <= mem[ra];
    end

    // header of q, taking the live copy of p when the two coincide
    assign q_hdr   = (r_q == r_p) ? {r_hp_link, r_hp_busy} : r_rdata;
    assign q_link  = q_hdr[HW-1:1];
    assign rd_link = r_rdata[HW-1:1];

    // step budget
    assign steps_inc = r_steps + SW'(1);
    assign over      = steps_inc > BUDGET;

    // fit test and split point
    assign span    = DW'(r_q) - DW'(r_p);
    assign fit     = (r_q > r_p) && (span >= DW'(r_need));
    assign cut_sum = DW'(r_p) + DW'(r_need);
    assign cut     = AW'(cut_sum);

    // free address check
    assign in_range = (r_ap != '0) && (CW'(r_ap) < CW'(TOP));
    assign ap_idx   = AW'(r_ap - RW'(1));

    // rounded word count plus header
    assign need_sum = NW'(i_request_bytes) + NW'(2 * BYTES_PER_WORD - 1);

    assign o_flags.pbusy    = r_rdata[0];
    assign o_flags.qbusy    = q_hdr[0];
    assign o_flags.over     = over;
    assign o_flags.nofit    = !fit;
    assign o_flags.advstop  = over || (!(r_hp_link > r_p) && r_wrapped);
    assign o_flags.outrange = !in_range;
    assign o_flags.clrlast  = (r_clr == TOP);

    assign o_status  = r_status;
    assign o_address = r_address;

    // operation decode
    always_comb begin
        ra        = '0;
        wa        = r_p;
        wd        = '0;
        we        = 1'b0;
        n_p       = r_p;
        n_q       = r_q;
        n_hp_link = r_hp_link;
        n_hp_busy = r_hp_busy;
        n_cut     = r_cut;
        n_clr     = r_clr;
        n_wrapped = r_wrapped;
        n_steps   = r_steps;
        n_need    = r_need;
        n_ap      = r_ap;
        n_rover   = r_rover;
        n_status  = r_status;
        n_address = r_address;
        unique case (i_ctrl.op)
            cffa_pkg::DP_IDLE: begin
                if (i_ctrl.start) begin
                    n_need = NW'(need_sum / BYTES_PER_WORD);
                    n_ap   = i_free_address;
                end
            end
            cffa_pkg::DP_ROVER: begin
                ra        = AW'(r_rover);
                n_p       = AW'(r_rover);
                n_steps   = '0;
                n_wrapped = 1'b0;
            end
            cffa_pkg::DP_LOADP: begin
                n_hp_link = rd_link;
                n_hp_busy = r_rdata[0];
                n_q       = rd_link;
                ra        = rd_link;
            end
            cffa_pkg::DP_MERGE: begin
                // absorb the free neighbor q into p
                if (!q_hdr[0]) begin
                    n_steps = steps_inc;
                    if (!over) begin
                        we        = 1'b1;
                        wa        = r_p;
                        wd        = {q_link, 1'b0};
                        n_hp_link = q_link;
                        n_q       = q_link;
                        ra        = q_link;
                    end
                end
            end
            cffa_pkg::DP_SPLIT: begin
                // write the remainder header
                if (fit) begin
                    n_cut = cut;
                    if (r_q > cut) begin
                        we = 1'b1;
                        wa = cut;
                        wd = {r_q, 1'b0};
                    end
                end
            end
            cffa_pkg::DP_TAKE: begin
                we        = 1'b1;
                wa        = r_p;
                wd        = {r_cut, 1'b1};
                n_rover   = RW'(r_cut);
                n_status  = cffa_pkg::ST_ALLOC;
                n_address = RW'({1'b0, r_p} + (AW + 1)'(1));
            end
            cffa_pkg::DP_ADVANCE: begin
                n_q     = r_p;
                n_p     = r_hp_link;
                ra      = r_hp_link;
                n_steps = steps_inc;
                if (!(r_hp_link > r_p)) begin
                    n_wrapped = 1'b1;
                end
            end
            cffa_pkg::DP_NOSPACE: begin
                n_rover   = RW'(TOP);
                n_status  = cffa_pkg::ST_NOSPACE;
                n_address = '0;
            end
            cffa_pkg::DP_FREERD: begin
                ra        = ap_idx;
                n_status  = cffa_pkg::ST_IGNORED;
                n_address = '0;
            end
            cffa_pkg::DP_FREEWR: begin
                we        = 1'b1;
                wa        = ap_idx;
                wd        = {rd_link, 1'b0};
                n_status  = cffa_pkg::ST_FREED;
                n_address = '0;
            end
            cffa_pkg::DP_HOLD: begin
                n_status = r_status;
            end
            cffa_pkg::DP_CLEAR: begin
                // reset image of the ring
                we    = 1'b1;
                wa    = r_clr;
                n_clr = r_clr + AW'(1);
                if (r_clr == '0) begin
                    wd = {TOP, 1'b0};
                end else if (r_clr == TOP) begin
                    wd = {AW'(0), 1'b1};
                end else begin
                    wd = '0;
                end
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rover <= '0;
            r_clr   <= '0;
        end else begin
            r_rover <= n_rover;
            r_clr   <= n_clr;
        end
    end

    // walk and result registers
    always_ff @(posedge i_clk) begin
        r_p       <= n_p;
        r_q       <= n_q;
        r_hp_link <= n_hp_link;
        r_hp_busy <= n_hp_busy;
        r_cut     <= n_cut;
        r_wrapped <= n_wrapped;
        r_steps   <= n_steps;
        r_need    <= n_need;
        r_ap      <= n_ap;
        r_status  <= n_status;
        r_address <= n_address;
    end

endmodule

// ----- hw/rtl/circular_first_fit_allocator_core.sv -----
// circular_first_fit_allocator_core: one request at a time. A free result reads the header
// and then writes it free; an out-of-range free skips the write. An allocate result follows
// a walk from the rover over busy headers, merges and free headers too small; a failed search
// ends in the no-space step. The next transfer is taken in the cycle after the result
// loads; a stalled result holds the core. Walks stop at 4 * ARENA_WORDS steps.
// Synchronous reset, then a clearing pass over all ARENA_WORDS headers rebuilds the ring.
module circular_first_fit_allocator_core #(
    parameter int ARENA_WORDS    = 1024,
    parameter int BYTES_PER_WORD = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_op,
    input  logic [cffa_pkg::REQ_W-1:0]  i_request_bytes,
    input  logic [cffa_pkg::ADDR_W-1:0] i_free_address,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_status,
    output logic [cffa_pkg::ADDR_W-1:0] o_address
);

    cffa_pkg::t_ctrl  ctrl;
    cffa_pkg::t_flags flags;
    logic             idle, load, out_free;
    logic [1:0]       dp_status;
    logic [cffa_pkg::ADDR_W-1:0] dp_address;

    logic       r_out_valid;
    logic [1:0] r_status;
    logic [cffa_pkg::ADDR_W-1:0] r_address;

    assign o_in_stall = !idle;
    assign out_free   = !r_out_valid || !i_out_stall;

    cffa_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_out_free (out_free),
        .i_flags    (flags),
        .o_ctrl     (ctrl),
        .o_idle     (idle),
        .o_load     (load)
    );

    cffa_dp #(
        .ARENA_WORDS    (ARENA_WORDS),
        .BYTES_PER_WORD (BYTES_PER_WORD)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_request_bytes (i_request_bytes),
        .i_free_address  (i_free_address),
        .o_flags         (flags),
        .o_status        (dp_status),
        .o_address       (dp_address)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status  <= dp_status;
            r_address <= dp_address;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_address   = r_address;

endmodule

// ----- hw/rtl/cffa_checker.sv -----
// cffa_checker: port-level checks for circular_first_fit_allocator_core,
// attached by the bind below. Depends on cffa_pkg.
module cffa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [1:0]                  o_status,
    input logic [cffa_pkg::ADDR_W-1:0] o_address
);

    // a held result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a held result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_status) && $stable(o_address))
        else $error("result changed while stalled");

    // only an allocation carries an address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != cffa_pkg::ST_ALLOC) |-> o_address == '0)
        else $error("nonzero address on a non-allocate result");

    // a transfer in keeps the block busy for the next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transfer taken while working");

endmodule

bind circular_first_fit_allocator_core cffa_checker u_cffa_checker (.*);

// ----- dv/cffa_tb_pkg.sv -----
// cffa_tb_pkg: request operation codes shared by the allocator checker and
// the testbench top. Depends on nothing.
package cffa_tb_pkg;

    // request operations on the input channel
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

// ----- dv/cffa_arena_checker.sv -----
// cffa_arena_checker: watches both channels of the allocator core, keeps its own
// ring of block headers and rover, predicts each reply and compares in order.
// Depends on cffa_pkg and cffa_tb_pkg.
module cffa_arena_checker #(
    parameter int ARENA_WORDS    = 1024,
    parameter int BYTES_PER_WORD = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_op,
    input  logic [cffa_pkg::REQ_W-1:0]  i_request_bytes,
    input  logic [cffa_pkg::ADDR_W-1:0] i_free_address,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [1:0]                  i_status,
    input  logic [cffa_pkg::ADDR_W-1:0] i_address,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_n_granted,
    output int                          o_n_refused,
    output int                          o_n_freed,
    output int                          o_n_ignored
);

    localparam int TOP_HDR     = ARENA_WORDS - 1;
    localparam int MAX_REPORTS = 10;
    localparam int AW          = cffa_pkg::ADDR_W;

    typedef struct packed {
        logic [1:0]    status;
        logic [AW-1:0] address;
    } t_reply;

    // header word: link in the upper bits, busy mark in bit 0
    logic [AW:0] arena_hdr [ARENA_WORDS];
    int          rover_ptr;
    t_reply      owed_replies [$];
    int          fails     = 0;
    int          n_granted = 0;
    int          n_refused = 0;
    int          n_freed   = 0;
    int          n_ignored = 0;

    function automatic int link_of(input int i);
        return int'(arena_hdr[i][AW:1]);
    endfunction

    function automatic logic [AW:0] pack_hdr(input int lnk, input logic busy);
        logic [AW-1:0] l;
        l = lnk[AW-1:0];
        return {l, busy};
    endfunction

    // first-fit walk from the rover with merging of free neighbours, one wrap
    task automatic first_fit_allocate(input int req, output t_reply r);
        int   need;
        int   budget;
        int   steps;
        int   p;
        int   q;
        int   cut;
        logic wrapped;
        logic done;
        need    = (req + 2 * BYTES_PER_WORD - 1) / BYTES_PER_WORD;
        budget  = 4 * ARENA_WORDS;
        steps   = 0;
        wrapped = 1'b0;
        done    = 1'b0;
        p       = rover_ptr;
        r.status  = cffa_pkg::ST_NOSPACE;
        r.address = '0;
        while (!done) begin
            if (!arena_hdr[p][0]) begin
                // absorb every free block that directly follows
                q = link_of(p);
                while (!done && !arena_hdr[q][0]) begin
                    steps++;
                    if (steps > budget) begin
                        done = 1'b1;
                    end else begin
                        arena_hdr[p] = pack_hdr(link_of(q), 1'b0);
                        q = link_of(p);
                    end
                end
                // take the block if it is large enough, split off the rest
                if (!done && q > p && q - p >= need) begin
                    cut = p + need;
                    if (q > cut) arena_hdr[cut] = pack_hdr(q, 1'b0);
                    arena_hdr[p] = pack_hdr(cut, 1'b1);
                    rover_ptr = cut;
                    r.status  = cffa_pkg::ST_ALLOC;
                    r.address = AW'(p + 1);
                    done = 1'b1;
                end
            end
            // step along the ring, at most one wrap
            if (!done) begin
                q = p;
                p = link_of(p);
                steps++;
                if (steps > budget) begin
                    done = 1'b1;
                end else if (p <= q) begin
                    if (wrapped) done = 1'b1;
                    else wrapped = 1'b1;
                end
            end
        end
        if (r.status != cffa_pkg::ST_ALLOC) rover_ptr = TOP_HDR;
    endtask

    always @(posedge i_clk) begin : watch
        t_reply want;
        t_reply got;
        int     adr;
        if (!i_rst_n) begin
            // ring of one free block up to the permanently busy top header
            for (int i = 0; i < ARENA_WORDS; i++) arena_hdr[i] = '0;
            arena_hdr[0]       = pack_hdr(TOP_HDR, 1'b0);
            arena_hdr[TOP_HDR] = pack_hdr(0, 1'b1);
            rover_ptr = 0;
            owed_replies.delete();
        end else begin
            // request transfer: predict its reply
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                if (i_op == cffa_tb_pkg::OP_ALLOC) begin
                    first_fit_allocate(int'(i_request_bytes), want);
                end else begin
                    adr = int'(i_free_address);
                    want.address = '0;
                    if (adr > 0 && adr < TOP_HDR) begin
                        arena_hdr[adr - 1][0] = 1'b0;
                        want.status = cffa_pkg::ST_FREED;
                    end else begin
                        want.status = cffa_pkg::ST_IGNORED;
                    end
                end
                owed_replies.push_back(want);
            end
            // reply transfer: compare with the oldest prediction
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                got.status  = i_status;
                got.address = i_address;
                case (got.status)
                    cffa_pkg::ST_ALLOC:   n_granted++;
                    cffa_pkg::ST_NOSPACE: n_refused++;
                    cffa_pkg::ST_FREED:   n_freed++;
                    default:              n_ignored++;
                endcase
                if (owed_replies.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: reply with nothing pending: status %0d address %0d",
                                 $time, got.status, got.address);
                end else begin
                    want = owed_replies.pop_front();
                    if (got.status !== want.status || got.address !== want.address) begin
                        fails++;
                        if (fails <= MAX_REPORTS) begin
                            $display("%0t: reply mismatch: expected status %0d address %0d",
                                     $time, want.status, want.address);
                            $display("    got status %0d address %0d",
                                     got.status, got.address);
                        end
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= owed_replies.size();
        o_n_granted  <= n_granted;
        o_n_refused  <= n_refused;
        o_n_freed    <= n_freed;
        o_n_ignored  <= n_ignored;
    end

endmodule

// ----- dv/tb_top.sv -----
// tb_top: drives allocate and free requests into circular_first_fit_allocator_core
// in bursts against a stalling reply side and gives the verdict.
// Depends on cffa_pkg, cffa_tb_pkg, cffa_arena_checker and the core.
module tb_top;

    localparam int ARENA_WORDS    = 1024;
    localparam int BYTES_PER_WORD = 4;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int DRAIN_CYCLES   = 64;
    localparam int REQ_W          = cffa_pkg::REQ_W;
    localparam int ADDR_W         = cffa_pkg::ADDR_W;
    // limit sized for the worst bounded walk on every item
    localparam int LIMIT_CYCLES   = 45_000_000;

    typedef enum int {RX_FLOW, RX_COIN, RX_LONG} t_rx_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_op;
    logic [REQ_W-1:0]  i_request_bytes;
    logic [ADDR_W-1:0] i_free_address;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [1:0]        o_status;
    logic [ADDR_W-1:0] o_address;

    int fail_count;
    int pending;
    int n_granted;
    int n_refused;
    int n_freed;
    int n_ignored;

    int                burst_left = 0;
    int                n_sent     = 0;
    logic [ADDR_W-1:0] live_blocks [$];

    t_rx_mode stall_mode = RX_FLOW;
    int       mode_left  = 0;
    int       stall_run  = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    circular_first_fit_allocator_core #(
        .ARENA_WORDS    (ARENA_WORDS),
        .BYTES_PER_WORD (BYTES_PER_WORD)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_request_bytes (i_request_bytes),
        .i_free_address  (i_free_address),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_address       (o_address)
    );

    cffa_arena_checker #(
        .ARENA_WORDS    (ARENA_WORDS),
        .BYTES_PER_WORD (BYTES_PER_WORD)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_request_bytes (i_request_bytes),
        .i_free_address  (i_free_address),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_status        (o_status),
        .i_address       (o_address),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_n_granted     (n_granted),
        .o_n_refused     (n_refused),
        .o_n_freed       (n_freed),
        .o_n_ignored     (n_ignored)
    );

    // reply side stalls: free flow, coin flips, or long runs
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = t_rx_mode'($urandom_range(0, 2));
            mode_left  = $urandom_range(20, 300);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            RX_FLOW: i_out_stall <= 1'b0;
            RX_COIN: i_out_stall <= 1'($urandom_range(0, 1));
            default: begin
                if (stall_run > 0) begin
                    stall_run--;
                    i_out_stall <= 1'b1;
                end else if ($urandom_range(0, 5) == 0) begin
                    stall_run = $urandom_range(1, 12);
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        endcase
    end

    // remember granted blocks so that most frees hit a live one
    always @(posedge i_clk) begin
        if (o_out_valid === 1'b1 && i_out_stall === 1'b0 && o_status == cffa_pkg::ST_ALLOC)
            live_blocks.push_back(o_address);
    end

    // one request transfer, then a gap once the current burst runs out
    task automatic push_request(input logic op, input int bytes, input int adr);
        int gap_len;
        i_in_valid      <= 1'b1;
        i_op            <= op;
        i_request_bytes <= bytes[REQ_W-1:0];
        i_free_address  <= adr[ADDR_W-1:0];
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        n_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(0, 15);
            if (gap_len > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap_len) @(posedge i_clk);
            end
        end
    endtask

    initial begin : stimulus
        int sel;
        int cls;
        int bytes;
        int idx;
        int adr;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_op            <= cffa_tb_pkg::OP_ALLOC;
        i_request_bytes <= '0;
        i_free_address  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // whole arena in one block, then nothing left
        push_request(cffa_tb_pkg::OP_ALLOC, 4088, 0);
        push_request(cffa_tb_pkg::OP_ALLOC, 0, 1023);
        // frees at both ends of the arena are ignored, then the whole block is freed
        push_request(cffa_tb_pkg::OP_FREE, 8191, 0);
        push_request(cffa_tb_pkg::OP_FREE, 0, 1023);
        push_request(cffa_tb_pkg::OP_FREE, 0, 1);
        // oversized requests, including the top of the field
        push_request(cffa_tb_pkg::OP_ALLOC, 4096, 0);
        push_request(cffa_tb_pkg::OP_ALLOC, 8191, 0);
        // header-only block and small ones carved from the front
        push_request(cffa_tb_pkg::OP_ALLOC, 0, 0);
        push_request(cffa_tb_pkg::OP_ALLOC, 1, 0);
        push_request(cffa_tb_pkg::OP_ALLOC, 4, 0);
        push_request(cffa_tb_pkg::OP_ALLOC, 5, 0);
        push_request(cffa_tb_pkg::OP_ALLOC, 100, 0);
        // free of a word that is no header, two neighbours, one twice
        push_request(cffa_tb_pkg::OP_FREE, 0, 1022);
        push_request(cffa_tb_pkg::OP_FREE, 0, 2);
        push_request(cffa_tb_pkg::OP_FREE, 0, 4);
        push_request(cffa_tb_pkg::OP_FREE, 0, 2);
        // fill almost to the top, then a search that merges, wraps and fails
        push_request(cffa_tb_pkg::OP_ALLOC, 12, 0);
        push_request(cffa_tb_pkg::OP_ALLOC, 3900, 0);
        push_request(cffa_tb_pkg::OP_ALLOC, 40, 0);
        // after a failed search the rover sits on the top header
        push_request(cffa_tb_pkg::OP_ALLOC, 8, 0);
        push_request(cffa_tb_pkg::OP_FREE, 0, 1021);

        // random mix: mostly moderate allocations and frees of live blocks
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 48) begin
                cls = $urandom_range(0, 99);
                if (cls < 12)      bytes = $urandom_range(0, 15);
                else if (cls < 80) bytes = $urandom_range(16, 400);
                else if (cls < 93) bytes = $urandom_range(401, 1600);
                else if (cls < 98) bytes = $urandom_range(1601, 4096);
                else               bytes = $urandom_range(4097, 8191);
                push_request(cffa_tb_pkg::OP_ALLOC, bytes, $urandom_range(0, 1023));
            end else if (sel < 92 && live_blocks.size() > 0) begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                adr = int'(live_blocks[idx]);
                live_blocks.delete(idx);
                push_request(cffa_tb_pkg::OP_FREE, $urandom_range(0, 8191), adr);
            end else begin
                push_request(cffa_tb_pkg::OP_FREE, $urandom_range(0, 8191),
                             $urandom_range(0, 1023));
            end
        end
        i_in_valid <= 1'b0;

        // let every reply arrive, then give the core time to settle
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: %0d allocations granted, %0d refused for lack of room",
                 n_sent, n_granted, n_refused);
        $display("        %0d frees applied, %0d frees out of range ignored",
                 n_freed, n_ignored);
        if (fail_count == 0 && pending == 0) begin
            $display("circular_first_fit_allocator_core verification clean");
        end else begin
            $display("circular_first_fit_allocator_core verification failed");
        end
        $finish;
    end

    // hard stop for a hung run
    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("circular_first_fit_allocator_core verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/cffa_pkg.sv
hw/rtl/cffa_seq.sv
hw/rtl/cffa_dp.sv
hw/rtl/circular_first_fit_allocator_core.sv
hw/rtl/cffa_checker.sv
dv/cffa_tb_pkg.sv
dv/cffa_arena_checker.sv
dv/tb_top.sv
